// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, suspended while reset is high.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Widths, request codes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // take the request on the input channel
    logic capture;  // latch the slot word returned by the RAM
  } deq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_read;  // the pending request is a pop on a non-empty queue
  } deq_sts_t;

endpackage

// ===== sv/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface deq_req_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pop_value;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: take a request, wait on the slot read, hold the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  deq_sts_t sts,
  output deq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   take;

  // Free when idle, or when the held result transfers in this cycle.
  assign in_ready  = (state == S_IDLE) || ((state == S_OUT) && out_ready);
  assign out_valid = (state == S_OUT);
  assign take      = in_valid && in_ready;

  assign cmd.load    = take;
  assign cmd.capture = (state == S_READ);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next = sts.needs_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (take) begin
          state_next = sts.needs_read ? S_READ : S_OUT;
        end else if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/deq_dp.sv =====
// ----------------------------------------------------------------------------
// deq_dp
// Ring pointers, fill count, slot RAM and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_dp import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  deq_cmd_t                 cmd,
  output deq_sts_t                 sts,
  input  logic [REQ_W-1:0]         req_type,
  input  logic signed [WORD_W-1:0] push_value,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [STATUS_W-1:0]      status,
  output logic [OCC_W-1:0]         occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [AW-1:0]       head, head_next, head_inc, head_dec, back_pos;
  logic [CW-1:0]       count, count_next, back_off;
  logic [SW-1:0]       back_sum;
  logic                full, empty, is_pop;
  logic [STATUS_W-1:0] status_next;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign is_pop = (req_type == REQ_POP_FRONT) || (req_type == REQ_POP_BACK);

  assign sts.needs_read = is_pop && !empty;

  // Back slot: head + count for a push, head + count - 1 for a back pop, wrapped once.
  assign back_off = (req_type == REQ_POP_BACK) ? count - 1'b1 : count;
  assign back_sum = SW'(head) + SW'(back_off);
  assign back_pos = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;

  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = ST_DONE;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = back_pos;
    ram_raddr   = back_pos;
    case (req_type)
      REQ_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ram_we     = cmd.load;
          count_next = count + 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ram_we     = cmd.load;
          ram_waddr  = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ram_re     = cmd.load;
          ram_raddr  = head;
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ram_re     = cmd.load;
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.load) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Result register: zero word on load, slot word dropped in on capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pop_value <= '0;
      status    <= status_next;
      occupancy <= OCC_W'(count_next);
    end else if (cmd.capture) begin
      pop_value <= ram_rdata;
    end
  end

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== sv/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words in a ring of DEPTH slots.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | role
//  --------+-----+----------------------------------+---------------------------
//  req     | in  | req_type, push_value             | push/pop request
//  rsp     | out | pop_value, status, occupancy     | one result per request
//
//  A push or a refused pop is answered in the cycle after its transfer; a
//  successful pop passes the read state, where the registered slot RAM read
//  is captured. A new request transfers when the block is idle or in the
//  cycle its result transfers, so none is taken in a pop's read. Synchronous
//  reset clears head, fill count and sequencer state; slots are never cleared
//  and need no sweep. A stalled result holds the request channel off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

`include "assert_macros.svh"

  deq_cmd_t cmd;
  deq_sts_t sts;

  // Shorthands for the checks at the end.
  logic req_xfer;
  logic req_is_push;
  logic rsp_empty;
  logic rsp_full;
  logic rsp_no_word;

  // Sequencer: owns the handshakes and tells the datapath when to act.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: pointer update and slot write happen in the transfer cycle,
  // a popped word goes through the RAM read register to the result register.
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .push_value (req.push_value),
    .pop_value  (rsp.pop_value),
    .status     (rsp.status),
    .occupancy  (rsp.occupancy)
  );

  assign req_xfer    = req.valid && req.ready;
  assign req_is_push = (req.req_type == REQ_PUSH_BACK) || (req.req_type == REQ_PUSH_FRONT);
  assign rsp_empty   = rsp.valid && (rsp.status == ST_EMPTY);
  assign rsp_full    = rsp.valid && (rsp.status == ST_FULL);
  assign rsp_no_word = (rsp.pop_value == '0);

  // A push is answered in the very next cycle.
  `DEQ_ASSERT(a_push_one_cycle, (req_xfer && req_is_push) |=> rsp.valid, "push result late")

  // Hold requests off while a result is stalled.
  `DEQ_ASSERT(a_stall_blocks, (rsp.valid && !rsp.ready) |-> !req.ready, "request over stall")

  // An empty report leaves the queue empty and returns no word.
  `DEQ_ASSERT(a_empty_result, rsp_empty |-> (rsp_no_word && rsp.occupancy == '0), "bad empty")

  // A refused push returns no word.
  `DEQ_ASSERT(a_full_result, rsp_full |-> rsp_no_word, "bad full result")

endmodule
